// ===== hw/rtl/gop_scan_pkg.sv =====
// Shared constants, codes and types of the GOP index scanner.
package gop_scan_pkg;

    localparam int POSITION_WIDTH = 48;
    localparam int FRAME_WIDTH    = 32;
    localparam int DIST_WIDTH     = 16;
    localparam int HIST_WIDTH     = 24;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int DIV_CNT_WIDTH  = $clog2(FRAME_WIDTH);

    localparam logic [HIST_WIDTH-1:0] PREFIX_CODE  = 24'h000001;
    localparam logic [3:0]            VIDEO_NIBBLE = 4'hE;
    localparam logic [7:0]            PICTURE_BYTE = 8'h00;
    localparam logic [7:0]            GOP_BYTE     = 8'hB8;

    localparam logic [DIST_WIDTH-1:0] GOP_DIST_RESET = DIST_WIDTH'(15);

    // Register index, taken from paddr[2]
    localparam logic REG_GOP_DIST = 1'b0;
    localparam logic REG_FULL_MAP = 1'b1;

    typedef struct packed {
        logic                   start;
        logic [FRAME_WIDTH-1:0] dividend;
        logic [DIST_WIDTH-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [FRAME_WIDTH-1:0] quotient;
    } div_rsp_t;

    // A zero distance is loaded as one so the divider never sees zero
    function automatic logic [DIST_WIDTH-1:0] load_distance(input logic [DIST_WIDTH-1:0] value);
        load_distance = (value == '0) ? DIST_WIDTH'(1) : value;
    endfunction

endpackage

// ===== hw/rtl/mpeg_gop_index_scanner_top.sv =====
// Top level of the MPEG GOP index scanner: start code tracking, APB registers, result register.
// A byte that emits no map entry shows its registered result in the cycle after it is accepted.
// Throughput: one byte per cycle while m_ready is held high (the next request is taken as the
// result is taken); a GOP code that emits a map entry holds s_ready low while the divider
// produces one quotient bit per cycle, then shows its result.
// Reset: synchronous, active low on aresetn; clears the history, counters and learning state,
// loads the GOP distance register and learned distance with 15 and clears the full map flag.
module mpeg_gop_index_scanner_top
    import gop_scan_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // input requests
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic [POSITION_WIDTH-1:0] s_byte_position,
    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_map_write,
    output logic [FRAME_WIDTH-1:0]    m_map_index,
    output logic [POSITION_WIDTH-1:0] m_map_position,
    output logic [FRAME_WIDTH-1:0]    m_frames_read,
    output logic [DIST_WIDTH-1:0]     m_gop_distance,
    output logic                      m_distance_learned,
    output logic                      m_pic_start,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [DIST_WIDTH-1:0] dflt_dist_reg, dflt_dist_next;
    logic                  full_map_reg, full_map_next;

    // scanner state
    logic [HIST_WIDTH-1:0]     hist_reg, hist_next;
    logic [FRAME_WIDTH-1:0]    frame_cnt_reg, frame_cnt_next;
    logic                      known_reg, known_next;
    logic [FRAME_WIDTH-1:0]    first_gop_reg, first_gop_next;
    logic [DIST_WIDTH-1:0]     dist_reg, dist_next;
    logic [FRAME_WIDTH-1:0]    key_frame_reg, key_frame_next;
    logic [POSITION_WIDTH-1:0] video_pos_reg, video_pos_next;

    // result register
    logic                      o_write_reg, o_write_next;
    logic [FRAME_WIDTH-1:0]    o_index_reg, o_index_next;
    logic [POSITION_WIDTH-1:0] o_pos_reg, o_pos_next;
    logic [FRAME_WIDTH-1:0]    o_frames_reg, o_frames_next;
    logic [DIST_WIDTH-1:0]     o_dist_reg, o_dist_next;
    logic                      o_learned_reg, o_learned_next;
    logic                      o_pic_reg, o_pic_next;

    logic accept;
    logic cfg_wr;
    logic was_prefix;
    logic is_video, is_picture, is_gop;
    logic learn_now;
    logic emit_map;
    logic [FRAME_WIDTH-1:0]            gop_diff;
    logic [FRAME_WIDTH+DIST_WIDTH-1:0] diff_ext;
    logic [DIST_WIDTH-1:0]             diff_sat;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Take a new request when idle, or as the waiting result is taken.
    assign s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = (state_reg == ST_OUT);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_FULL_MAP) ?
                    {{(APB_DATA_WIDTH-1){1'b0}}, full_map_reg} :
                    {{(APB_DATA_WIDTH-DIST_WIDTH){1'b0}}, dflt_dist_reg};

    // Start code decode: history held 00 00 01 before this byte
    assign was_prefix = (hist_reg == PREFIX_CODE);
    assign is_video   = was_prefix && (s_data_byte[7:4] == VIDEO_NIBBLE);
    assign is_picture = was_prefix && (s_data_byte == PICTURE_BYTE);
    assign is_gop     = was_prefix && (s_data_byte == GOP_BYTE);

    // GOP distance learning: saturate the wrapped frame difference to the distance width
    assign gop_diff  = frame_cnt_reg - first_gop_reg;
    assign diff_ext  = {{DIST_WIDTH{1'b0}}, gop_diff};
    assign diff_sat  = (diff_ext[FRAME_WIDTH+DIST_WIDTH-1:DIST_WIDTH] != '0) ?
                       {DIST_WIDTH{1'b1}} : diff_ext[DIST_WIDTH-1:0];
    assign learn_now = is_gop && !known_reg && (frame_cnt_reg != '0) &&
                       (first_gop_reg != '0) && (gop_diff != '0);
    assign emit_map  = is_gop && !full_map_reg;

    always_comb begin
        hist_next      = hist_reg;
        frame_cnt_next = frame_cnt_reg;
        known_next     = known_reg;
        first_gop_next = first_gop_reg;
        dist_next      = dist_reg;
        key_frame_next = key_frame_reg;
        video_pos_next = video_pos_reg;
        dflt_dist_next = dflt_dist_reg;
        full_map_next  = full_map_reg;

        if (accept) begin
            hist_next = {hist_reg[HIST_WIDTH-9:0], s_data_byte};
            if (is_video) begin
                // record the offset of the code's first byte
                video_pos_next = s_byte_position - POSITION_WIDTH'(3);
            end
            if (is_picture) begin
                frame_cnt_next = frame_cnt_reg + FRAME_WIDTH'(1);
            end
            if (is_gop) begin
                key_frame_next = frame_cnt_reg;
                if (!known_reg && (frame_cnt_reg != '0) && (first_gop_reg == '0)) begin
                    first_gop_next = frame_cnt_reg;
                end
                if (learn_now) begin
                    dist_next  = diff_sat;
                    known_next = 1'b1;
                end
            end
        end

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_GOP_DIST: begin
                    dflt_dist_next = pwdata[DIST_WIDTH-1:0];
                    // reload the working distance only until one is learned
                    if (!known_reg) begin
                        dist_next = load_distance(pwdata[DIST_WIDTH-1:0]);
                    end
                end
                REG_FULL_MAP: begin
                    full_map_next = pwdata[0];
                end
                default: begin
                    full_map_next = full_map_reg;
                end
            endcase
        end
    end

    // Divide the key frame by the distance in force after this byte
    assign div_req.start    = accept && emit_map;
    assign div_req.dividend = frame_cnt_reg;
    assign div_req.divisor  = dist_next;

    gop_scan_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        o_write_next   = o_write_reg;
        o_index_next   = o_index_reg;
        o_pos_next     = o_pos_reg;
        o_frames_next  = o_frames_reg;
        o_dist_next    = o_dist_reg;
        o_learned_next = o_learned_reg;
        o_pic_next     = o_pic_reg;

        if (accept) begin
            o_write_next   = emit_map;
            o_index_next   = '0;
            o_pos_next     = emit_map ? video_pos_reg : '0;
            o_frames_next  = frame_cnt_next;
            o_dist_next    = dist_next;
            o_learned_next = learn_now;
            o_pic_next     = is_picture;
            state_next     = emit_map ? ST_DIV : ST_OUT;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    state_next = ST_IDLE;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        o_index_next = div_rsp.quotient;
                        state_next   = ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dflt_dist_reg <= GOP_DIST_RESET;
            full_map_reg  <= 1'b0;
            hist_reg      <= '0;
            frame_cnt_reg <= '0;
            known_reg     <= 1'b0;
            first_gop_reg <= '0;
            dist_reg      <= load_distance(GOP_DIST_RESET);
            key_frame_reg <= '0;
            video_pos_reg <= '0;
        end else begin
            state_reg     <= state_next;
            dflt_dist_reg <= dflt_dist_next;
            full_map_reg  <= full_map_next;
            hist_reg      <= hist_next;
            frame_cnt_reg <= frame_cnt_next;
            known_reg     <= known_next;
            first_gop_reg <= first_gop_next;
            dist_reg      <= dist_next;
            key_frame_reg <= key_frame_next;
            video_pos_reg <= video_pos_next;
        end
        o_write_reg   <= o_write_next;
        o_index_reg   <= o_index_next;
        o_pos_reg     <= o_pos_next;
        o_frames_reg  <= o_frames_next;
        o_dist_reg    <= o_dist_next;
        o_learned_reg <= o_learned_next;
        o_pic_reg     <= o_pic_next;
    end

    assign m_map_write        = o_write_reg;
    assign m_map_index        = o_index_reg;
    assign m_map_position     = o_pos_reg;
    assign m_frames_read      = o_frames_reg;
    assign m_gop_distance     = o_dist_reg;
    assign m_distance_learned = o_learned_reg;
    assign m_pic_start        = o_pic_reg;

endmodule

// ===== hw/rtl/gop_scan_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gop_scan_div
    import gop_scan_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                     busy_reg, busy_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [DIST_WIDTH-1:0]    rem_reg, rem_next;
    logic [FRAME_WIDTH-1:0]   quo_reg, quo_next;
    logic [DIST_WIDTH-1:0]    dvs_reg, dvs_next;
    logic                     done_reg, done_next;
    logic [DIST_WIDTH:0]      trial;
    logic                     fits;

    assign trial = {rem_reg, quo_reg[FRAME_WIDTH-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = fits ? DIST_WIDTH'(trial - {1'b0, dvs_reg}) : trial[DIST_WIDTH-1:0];
            quo_next = {quo_reg[FRAME_WIDTH-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_WIDTH'(1);
            if (cnt_reg == DIV_CNT_WIDTH'(FRAME_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/gop_scan_chk.sv =====
// Port-level checker of the GOP index scanner and its bind to the top level.
module gop_scan_chk
    import gop_scan_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_map_write,
    input logic [FRAME_WIDTH-1:0]    m_map_index,
    input logic [POSITION_WIDTH-1:0] m_map_position,
    input logic [DIST_WIDTH-1:0]     m_gop_distance,
    input logic                      m_pic_start
);

    // a stalled result blocks new requests
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while result stalled");

    a_gop_not_picture: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_map_write && m_pic_start))
        else $error("map write and picture start on one byte");

    a_dist_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gop_distance != '0))
        else $error("zero GOP distance");

    a_no_map_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_map_write) |-> ((m_map_index == '0) && (m_map_position == '0)))
        else $error("map fields set without map write");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_map_index)))
        else $error("stalled result changed");

endmodule

bind mpeg_gop_index_scanner_top gop_scan_chk u_gop_scan_chk (.*);
